[src/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the perfect square / cube counter.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int VALUE_W   = 32;
	localparam int TALLY_W   = 32;
	localparam int SQ_BITS   = 16;   // root bits of a 32-bit square root
	localparam int CB_BITS   = 11;   // root bits of a 32-bit cube root
	localparam int MUL_A_W   = 22;   // holds root squared for the cube step
	localparam int MUL_B_W   = 16;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int OUT_W     = 72;   // 66 payload bits padded to bytes

	localparam logic [MUL_B_W-1:0] SQ_BIT_INIT = MUL_B_W'(1) << (SQ_BITS - 1);
	localparam logic [MUL_B_W-1:0] CB_BIT_INIT = MUL_B_W'(1) << (CB_BITS - 1);
	localparam logic [TALLY_W-1:0] TALLY_MAX   = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_MUL,
		ST_SQ_CMP,
		ST_CB_MUL1,
		ST_CB_MUL2,
		ST_CB_CMP,
		ST_DONE
	} root_state_t;

	typedef struct packed {
		logic is_square;
		logic is_cube;
	} root_flags_t;

endpackage

[src/psc_mul.sv]
// ----------------------------------------------------------------------------
// psc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module psc_mul (
	input  logic                       clk,
	input  logic [psc_pkg::MUL_A_W-1:0] a,
	input  logic [psc_pkg::MUL_B_W-1:0] b,
	output logic [psc_pkg::PROD_W-1:0]  prod
);
	import psc_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

[src/psc_root.sv]
// ----------------------------------------------------------------------------
// psc_root
// Bit-serial square root and cube root search on one shared multiplier;
// flags the value as a square and/or a cube.
// ----------------------------------------------------------------------------
module psc_root (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [psc_pkg::VALUE_W-1:0] value,
	output logic                        ready,
	output logic                        res_valid,
	input  logic                        res_ack,
	output psc_pkg::root_flags_t        res
);
	import psc_pkg::*;

	root_state_t          state_q, state_d;
	logic [VALUE_W-1:0]   v_q;
	logic [SQ_BITS-1:0]   root_sq_q;
	logic [CB_BITS-1:0]   root_cb_q;
	logic [MUL_B_W-1:0]   bit_q;
	logic                 sq_eq_q, cb_eq_q;

	logic [SQ_BITS-1:0]   sq_t;
	logic [CB_BITS-1:0]   cb_t;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    v_ext;
	logic                 prod_le, prod_eq;

	assign sq_t    = root_sq_q | bit_q[SQ_BITS-1:0];
	assign cb_t    = root_cb_q | bit_q[CB_BITS-1:0];
	assign v_ext   = PROD_W'(v_q);
	assign prod_le = prod <= v_ext;
	assign prod_eq = prod == v_ext;

	psc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (value[VALUE_W-1] || value == '0) state_d = ST_DONE;
					else state_d = ST_SQ_MUL;
				end
			end
			ST_SQ_MUL:  state_d = ST_SQ_CMP;
			ST_SQ_CMP:  state_d = bit_q[0] ? ST_CB_MUL1 : ST_SQ_MUL;
			ST_CB_MUL1: state_d = ST_CB_MUL2;
			ST_CB_MUL2: state_d = ST_CB_CMP;
			ST_CB_CMP:  state_d = bit_q[0] ? ST_DONE : ST_CB_MUL1;
			ST_DONE: begin
				if (res_ack) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		ready     = 1'b0;
		res_valid = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE:    ready = 1'b1;
			ST_SQ_MUL: begin
				mul_a = MUL_A_W'(sq_t);
				mul_b = MUL_B_W'(sq_t);
			end
			ST_CB_MUL1: begin
				mul_a = MUL_A_W'(cb_t);
				mul_b = MUL_B_W'(cb_t);
			end
			ST_CB_MUL2: begin
				// t*t from the previous cycle times t
				mul_a = prod[MUL_A_W-1:0];
				mul_b = MUL_B_W'(cb_t);
			end
			ST_DONE:    res_valid = 1'b1;
			default: begin
				mul_a = '0;
			end
		endcase
	end

	assign res.is_square = sq_eq_q;
	assign res.is_cube   = cb_eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath; an exact match seen during the search means a perfect power
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					v_q       <= value;
					root_sq_q <= '0;
					root_cb_q <= '0;
					bit_q     <= SQ_BIT_INIT;
					sq_eq_q   <= (value == '0);
					cb_eq_q   <= (value == '0);
				end
			end
			ST_SQ_CMP: begin
				if (prod_le) root_sq_q <= sq_t;
				if (prod_eq) sq_eq_q <= 1'b1;
				bit_q <= bit_q[0] ? CB_BIT_INIT : (bit_q >> 1);
			end
			ST_CB_CMP: begin
				if (prod_le) root_cb_q <= cb_t;
				if (prod_eq) cb_eq_q <= 1'b1;
				bit_q <= bit_q >> 1;
			end
			default: begin
				bit_q <= bit_q;
			end
		endcase
	end

endmodule

[src/perfect_square_cube_counter_core.sv]
// A positive value runs 16 square-root steps (ST_SQ_MUL, ST_SQ_CMP) and 11
// cube-root steps (ST_CB_MUL1, ST_CB_MUL2, ST_CB_CMP) on one shared
// multiplier; zero or a negative value goes from idle straight to done.
// The search takes no new request until it is back in idle; the next one
// is taken while the previous result waits in the output register.
// Reset: arst_n clears both tallies and the sequencer, no result pending.
// ----------------------------------------------------------------------------
// perfect_square_cube_counter_core
// Flags perfect squares and cubes in a stream and keeps saturating counts.
// ----------------------------------------------------------------------------
module perfect_square_cube_counter_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,   // [31:0] value
	input  logic [0:0]                s_tuser,   // [0] first
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [0] is_square, [1] is_cube, [33:2] square_total, [65:34] cube_total
	output logic [psc_pkg::OUT_W-1:0] m_tdata
);
	import psc_pkg::*;

	logic                 root_ready, res_valid, res_ack;
	root_flags_t          res;
	logic                 first_q;
	logic [TALLY_W-1:0]   square_tally_q, cube_tally_q;
	logic [TALLY_W-1:0]   sq_base, cb_base, sq_new, cb_new;
	logic                 out_valid_q;
	root_flags_t          out_flags_q;

	psc_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_tvalid),
		.value     (s_tdata[VALUE_W-1:0]),
		.ready     (root_ready),
		.res_valid (res_valid),
		.res_ack   (res_ack),
		.res       (res)
	);

	assign s_tready = root_ready;
	assign res_ack  = !out_valid_q || m_tready;

	// first request of a run restarts both counts before counting itself
	assign sq_base = first_q ? '0 : square_tally_q;
	assign cb_base = first_q ? '0 : cube_tally_q;
	assign sq_new  = (res.is_square && sq_base != TALLY_MAX) ? sq_base + 1'b1 : sq_base;
	assign cb_new  = (res.is_cube && cb_base != TALLY_MAX) ? cb_base + 1'b1 : cb_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			square_tally_q <= '0;
			cube_tally_q   <= '0;
			first_q        <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) first_q <= s_tuser[0];
			if (res_valid && res_ack) begin
				square_tally_q <= sq_new;
				cube_tally_q   <= cb_new;
				out_valid_q    <= 1'b1;
			end else if (m_tready) begin
				out_valid_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ack) out_flags_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, cube_tally_q, square_tally_q,
		out_flags_q.is_cube, out_flags_q.is_square};

endmodule

[tb/tb_perfect_square_cube_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perfect_square_cube_counter_core
// Streams signed values into the square/cube counter and checks every result
// (both flags and both running counts) against a predictor kept in the bench.
// Directed corners and first-flag cases come first, then a long random stream
// with random source gaps and sink stalls, plus stretches at full rate.
// ----------------------------------------------------------------------------
module tb_perfect_square_cube_counter_core;
	import psc_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int RESET_CYC   = 7;
	localparam int GAP_MAX     = 18;
	localparam int DRAIN_CYC   = 150;
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic               is_square;
		logic               is_cube;
		logic [TALLY_W-1:0] square_total;
		logic [TALLY_W-1:0] cube_total;
	} verdict_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;
	logic [0:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;

	// predictor state
	logic [TALLY_W-1:0]  model_square_count;
	logic [TALLY_W-1:0]  model_cube_count;
	verdict_t            pending_verdicts[$];

	int src_gap_max;
	int sink_gap_max;
	int requests_sent;
	int results_checked;
	int squares_seen;
	int cubes_seen;
	int clears_sent;
	int fail_count;

	perfect_square_cube_counter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// floor of the square root (cubic = 0) or cube root (cubic = 1), by bisection
	function automatic logic [31:0] root_floor(input logic [31:0] v, input logic cubic);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] pwr;
		lo = 0;
		hi = cubic ? 64'd1625 : 64'd65535;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			pwr = cubic ? mid * mid * mid : mid * mid;
			if (pwr <= {32'd0, v})
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo[31:0];
	endfunction

	// updates the model counts and returns what the block must report
	function automatic verdict_t predict_square_cube(input logic [31:0] v, input logic clear);
		verdict_t    r;
		logic [63:0] sr;
		logic [63:0] cr;
		r = '0;
		if (!v[31]) begin
			sr = {32'd0, root_floor(v, 1'b0)};
			cr = {32'd0, root_floor(v, 1'b1)};
			r.is_square = (sr * sr == {32'd0, v});
			r.is_cube   = (cr * cr * cr == {32'd0, v});
		end
		if (clear) begin
			model_square_count = '0;
			model_cube_count   = '0;
		end
		if (r.is_square && model_square_count != TALLY_MAX)
			model_square_count = model_square_count + 1;
		if (r.is_cube && model_cube_count != TALLY_MAX)
			model_cube_count = model_cube_count + 1;
		r.square_total = model_square_count;
		r.cube_total   = model_cube_count;
		return r;
	endfunction

	// one request; valid stays high into the next call when no gap is drawn
	task automatic send_value(input logic [31:0] v, input logic clear);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tuser  <= clear;
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_verdicts.push_back(predict_square_cube(v, clear));
		requests_sent++;
		if (clear)
			clears_sent++;
	endtask

	task automatic idle_source();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [31:0] random_value();
		logic [31:0] r;
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0, 1: begin
				r = $urandom_range(0, 46340);
				return r * r;
			end
			2, 3: begin
				r = $urandom_range(0, 1290);
				return r * r * r;
			end
			4: begin
				r = $urandom_range(1, 46340);
				return w[0] ? r * r + 1 : r * r - 1;
			end
			5: begin
				r = $urandom_range(2, 1290);
				return w[0] ? r * r * r + 1 : r * r * r - 1;
			end
			6: return $urandom_range(0, 70);
			7: return {1'b1, w[30:0]};
			default: return w;
		endcase
	endfunction

	task automatic test_corner_values();
		logic [31:0] corners[$];
		src_gap_max  = GAP_MAX;
		sink_gap_max = GAP_MAX;
		corners = '{32'd0, 32'd1, 32'd2, 32'd4, 32'd8, 32'd9, 32'd15, 32'd26, 32'd27,
			32'd64, 32'd729, 32'd46656, 32'd1000000, 32'd1073741824,
			32'd2147395600, 32'd2147395601, 32'd2146689000, 32'd2146688999,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFC};
		foreach (corners[i])
			send_value(corners[i], i == 0);
		idle_source();
	endtask

	task automatic test_first_flag();
		src_gap_max  = 0;
		sink_gap_max = GAP_MAX;
		send_value(32'hFFFF_FFF8, 1'b1);   // clear on a negative: both counts stay zero
		send_value(32'd16, 1'b0);
		send_value(32'd17, 1'b1);          // clear on a non-root
		send_value(32'd0, 1'b1);           // clear then count zero as both
		send_value(32'd0, 1'b1);
		send_value(32'd125, 1'b0);
		idle_source();
	endtask

	task automatic test_random_stream(input int n, input int src_max, input int sink_max);
		src_gap_max  = src_max;
		sink_gap_max = sink_max;
		repeat (n)
			send_value(random_value(), $urandom_range(0, 15) == 0);
		idle_source();
	endtask

	// result checker
	initial begin : result_monitor
		int       stall;
		verdict_t want;
		verdict_t got;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, sink_gap_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got.is_square    = m_tdata[0];
			got.is_cube      = m_tdata[1];
			got.square_total = m_tdata[33:2];
			got.cube_total   = m_tdata[65:34];
			results_checked++;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result, data %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.is_square !== want.is_square) begin
					$display("%0t: is_square expected %b actual %b", $time,
						want.is_square, got.is_square);
					fail_count++;
				end
				if (got.is_cube !== want.is_cube) begin
					$display("%0t: is_cube expected %b actual %b", $time,
						want.is_cube, got.is_cube);
					fail_count++;
				end
				if (got.square_total !== want.square_total) begin
					$display("%0t: square_total expected %0d actual %0d", $time,
						want.square_total, got.square_total);
					fail_count++;
				end
				if (got.cube_total !== want.cube_total) begin
					$display("%0t: cube_total expected %0d actual %0d", $time,
						want.cube_total, got.cube_total);
					fail_count++;
				end
				if (want.is_square)
					squares_seen++;
				if (want.is_cube)
					cubes_seen++;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout, %0d results still pending", $time, pending_verdicts.size());
		$display("perfect_square_cube_counter_core test failed");
		$finish;
	end

	initial begin : main_seq
		arst_n             = 1'b0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		s_tuser            = '0;
		model_square_count = '0;
		model_cube_count   = '0;
		src_gap_max        = 0;
		sink_gap_max       = 0;
		requests_sent      = 0;
		results_checked    = 0;
		squares_seen       = 0;
		cubes_seen         = 0;
		clears_sent        = 0;
		fail_count         = 0;
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_corner_values();
		test_first_flag();
		test_random_stream(1000, GAP_MAX, GAP_MAX);
		test_random_stream(300, 0, 0);            // full rate both sides
		test_random_stream(300, 0, GAP_MAX);      // sink-limited

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Sent %0d requests (%0d with count clear), checked %0d results",
			requests_sent, clears_sent, results_checked);
		$display("Covered %0d squares and %0d cubes, incl. zero, negatives and range limits",
			squares_seen, cubes_seen);
		if (fail_count == 0)
			$display("perfect_square_cube_counter_core test passed");
		else
			$display("perfect_square_cube_counter_core test failed");
		$finish;
	end

endmodule

[files.f]
src/psc_pkg.sv
src/psc_mul.sv
src/psc_root.sv
src/perfect_square_cube_counter_core.sv
tb/tb_perfect_square_cube_counter_core.sv
